FILE: rtl/busiest_server_dispatcher_core_defines.svh
// Assertion macros shared by the dispatcher RTL
`ifndef BUSIEST_SERVER_DISPATCHER_CORE_DEFINES_SVH
`define BUSIEST_SERVER_DISPATCHER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define BSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define BSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bsd_pkg.sv
// Types and constants for the busiest-server dispatcher
`default_nettype none

package bsd_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int SRV_W    = 4;
    localparam int CFG_W    = 5;
    localparam int CMP_W    = TIME_W + 1;

    localparam int MAX_RESULTS = 16;
    localparam int EMIT_W      = 5;

    localparam logic [CFG_W-1:0] SERVER_COUNT_RST = 5'd16;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_REPORT  = 1'b1;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/bsd_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module bsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/bsd_cmp.sv
// Shared magnitude comparator used by every scan of the sequencer
`default_nettype none

module bsd_cmp (
    input  wire logic [bsd_pkg::CMP_W-1:0] a,
    input  wire logic [bsd_pkg::CMP_W-1:0] b,
    output bsd_pkg::cmp_res_t               res
);

    import bsd_pkg::*;

    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
        res.gt = (a > b);
    end

endmodule

`default_nettype wire

FILE: rtl/busiest_server_dispatcher_core.sv
// Busiest-server dispatcher: round-robin assignment with busy timers and a busiest report
//
// One word is taken at a time; req_stall stays high until the word's last result has
// been loaded into the output register. A request sweeps the k servers in use
// (k = server_count clamped to 1..NUM_SERVERS) once, one server per cycle through the
// shared comparator and the registered server RAMs. Before that sweep, one subtraction
// per step brings the start pointer back below k after server_count has shrunk, and the
// result is loaded only once the previous one is no longer held by rsp_stall. A report
// sweeps the servers twice, once to find the largest handled count and once to emit
// the ties; the emitting pass holds while the output side stalls. The output register
// lets the next word be taken while the final result still waits on rsp_stall. No
// clearing pass is needed after reset.
`default_nettype none
`include "busiest_server_dispatcher_core_defines.svh"

module busiest_server_dispatcher_core #(
    parameter int NUM_SERVERS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          server_count_we,
    input  wire logic [bsd_pkg::CFG_W-1:0]     server_count_wdata,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic                          action,
    input  wire logic [bsd_pkg::TIME_W-1:0]    arrival_time,
    input  wire logic [bsd_pkg::TIME_W-1:0]    duration,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic                               kind,
    output logic                               accepted,
    output logic      [bsd_pkg::SRV_W-1:0]     server,
    output logic      [bsd_pkg::COUNT_W-1:0]   handled,
    output logic                               last
);

    import bsd_pkg::*;

    localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int CW = $clog2(NUM_SERVERS + 1);
    localparam int TW = 8;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_PRIME = 3'd2;
    localparam logic [2:0] ST_REQ   = 3'd3;
    localparam logic [2:0] ST_MAX   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [CW-1:0]    K_MAX     = CW'(NUM_SERVERS);
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    // control state
    logic [2:0]             state_reg, state_next;
    logic [CFG_W-1:0]       server_count_reg;
    logic [IW-1:0]          sp_reg, sp_next;
    logic [IW-1:0]          cur_reg, cur_next;
    logic [CW-1:0]          step_reg, step_next;
    logic                   found_reg, found_next;
    logic                   pass2_reg, pass2_next;
    logic [CW-1:0]          ties_reg, ties_next;
    logic [EMIT_W-1:0]      emit_n_reg, emit_n_next;
    logic [NUM_SERVERS-1:0] busy_reg, busy_next;
    logic [NUM_SERVERS-1:0] hval_reg, hval_next;
    logic                   out_valid_reg, out_valid_next;

    // payload
    logic                   op_reg;
    logic [TIME_W-1:0]      arrival_reg;
    logic [TIME_W-1:0]      duration_reg;
    logic [IW-1:0]          tgt_reg, tgt_next;
    logic [COUNT_W-1:0]     tgt_cnt_reg, tgt_cnt_next;
    logic [COUNT_W-1:0]     best_reg, best_next;
    logic                   kind_reg, kind_next;
    logic                   acc_reg, acc_next;
    logic [SRV_W-1:0]       srv_reg, srv_next;
    logic [COUNT_W-1:0]     handled_reg, handled_next;
    logic                   last_reg, last_next;

    logic [CW-1:0]          k_w;
    logic [IW-1:0]          nxt_idx;
    logic                   last_step;
    logic                   slot_free;
    logic                   adv;
    logic [IW-1:0]          rd_addr;
    logic [CMP_W-1:0]       bu_rdata;
    logic [COUNT_W-1:0]     hc_rdata;
    logic [COUNT_W-1:0]     cnt_rd;
    logic [COUNT_W-1:0]     cnt_inc;
    logic [CMP_W-1:0]       bu_wdata;
    logic                   ram_we;
    logic [CMP_W-1:0]       cmp_a, cmp_b;
    cmp_res_t               cmp_res;
    logic                   srv_free;
    logic                   emit_last;
    logic                   accept_in;

    // servers in use: clamp to 1..NUM_SERVERS
    always_comb
    begin
        if (server_count_reg == '0)
        begin
            k_w = CW'(1);
        end
        else if (TW'(server_count_reg) > TW'(NUM_SERVERS))
        begin
            k_w = K_MAX;
        end
        else
        begin
            k_w = CW'(server_count_reg);
        end
    end

    assign nxt_idx   = ((CW'(cur_reg) + CW'(1)) == k_w) ? '0 : IW'(CW'(cur_reg) + CW'(1));
    assign last_step = (step_reg == (k_w - CW'(1)));
    assign slot_free = !out_valid_reg || !rsp_stall;
    assign accept_in = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);

    assign cnt_rd  = hval_reg[cur_reg] ? hc_rdata : '0;
    assign cnt_inc = (tgt_cnt_reg == COUNT_SAT) ? tgt_cnt_reg : tgt_cnt_reg + COUNT_W'(1);
    assign bu_wdata = {1'b0, arrival_reg} + {1'b0, duration_reg};
    assign ram_we  = (state_reg == ST_DONE) && slot_free && found_reg;

    // the one comparator: release test on requests, count test on reports
    always_comb
    begin
        if (state_reg == ST_REQ)
        begin
            cmp_a = bu_rdata;
            cmp_b = {1'b0, arrival_reg};
        end
        else
        begin
            cmp_a = {1'b0, cnt_rd};
            cmp_b = {1'b0, best_reg};
        end
    end

    bsd_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign srv_free  = !busy_reg[cur_reg] || !cmp_res.gt;
    assign emit_last = (TW'(emit_n_reg) + TW'(1) == TW'(ties_reg))
                    || (TW'(emit_n_reg) + TW'(1) == TW'(MAX_RESULTS));

    // hold the scan on a report match while the output register is full
    always_comb
    begin
        adv = 1'b0;
        unique case (state_reg) inside
            ST_REQ, ST_MAX: adv = 1'b1;
            ST_EMIT:        adv = !(cmp_res.eq && !slot_free);
            default:        adv = 1'b0;
        endcase
    end

    assign rd_addr = adv ? nxt_idx : cur_reg;

    bsd_ram #(
        .WIDTH (CMP_W),
        .DEPTH (NUM_SERVERS)
    ) u_busy_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_reg),
        .wdata (bu_wdata),
        .raddr (rd_addr),
        .rdata (bu_rdata)
    );

    bsd_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_SERVERS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_reg),
        .wdata (cnt_inc),
        .raddr (rd_addr),
        .rdata (hc_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        cur_next       = cur_reg;
        step_next      = step_reg;
        found_next     = found_reg;
        pass2_next     = pass2_reg;
        ties_next      = ties_reg;
        emit_n_next    = emit_n_reg;
        busy_next      = busy_reg;
        hval_next      = hval_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        tgt_next       = tgt_reg;
        tgt_cnt_next   = tgt_cnt_reg;
        best_next      = best_reg;
        kind_next      = kind_reg;
        acc_next       = acc_reg;
        srv_next       = srv_reg;
        handled_next   = handled_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    cur_next   = '0;
                    step_next  = '0;
                    found_next = 1'b0;
                    pass2_next = 1'b0;
                    best_next  = '0;
                    ties_next  = '0;
                    state_next = (action == ACT_REQUEST) ? ST_MOD : ST_PRIME;
                end
            end
            ST_MOD:
            begin
                // bring the start pointer below the current server count
                if (CW'(sp_reg) >= k_w)
                begin
                    sp_next = IW'(CW'(sp_reg) - k_w);
                end
                else
                begin
                    cur_next   = sp_reg;
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                if (op_reg == ACT_REQUEST)
                begin
                    state_next = ST_REQ;
                end
                else
                begin
                    state_next = pass2_reg ? ST_EMIT : ST_MAX;
                end
            end
            ST_REQ:
            begin
                if (busy_reg[cur_reg] && !cmp_res.gt)
                begin
                    busy_next[cur_reg] = 1'b0;
                end
                if (srv_free && !found_reg)
                begin
                    found_next   = 1'b1;
                    tgt_next     = cur_reg;
                    tgt_cnt_next = cnt_rd;
                end
                cur_next  = nxt_idx;
                step_next = step_reg + CW'(1);
                if (last_step)
                begin
                    sp_next    = ((CW'(sp_reg) + CW'(1)) >= k_w) ? '0
                                 : IW'(CW'(sp_reg) + CW'(1));
                    state_next = ST_DONE;
                end
            end
            ST_MAX:
            begin
                if (cmp_res.gt)
                begin
                    best_next = cnt_rd;
                    ties_next = CW'(1);
                end
                else if (cmp_res.eq)
                begin
                    ties_next = ties_reg + CW'(1);
                end
                cur_next  = nxt_idx;
                step_next = step_reg + CW'(1);
                if (last_step)
                begin
                    cur_next    = '0;
                    step_next   = '0;
                    pass2_next  = 1'b1;
                    emit_n_next = '0;
                    state_next  = ST_PRIME;
                end
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    cur_next  = nxt_idx;
                    step_next = step_reg + CW'(1);
                    if (last_step)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                if (cmp_res.eq && slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_REPORT;
                    acc_next       = 1'b0;
                    srv_next       = SRV_W'(cur_reg);
                    handled_next   = best_reg;
                    last_next      = emit_last;
                    emit_n_next    = emit_n_reg + EMIT_W'(1);
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ASSIGN;
                    acc_next       = found_reg;
                    srv_next       = found_reg ? SRV_W'(tgt_reg) : '0;
                    handled_next   = found_reg ? cnt_inc : '0;
                    last_next      = 1'b1;
                    if (found_reg)
                    begin
                        busy_next[tgt_reg] = 1'b1;
                        hval_next[tgt_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            server_count_reg <= SERVER_COUNT_RST;
            sp_reg           <= '0;
            cur_reg          <= '0;
            step_reg         <= '0;
            found_reg        <= 1'b0;
            pass2_reg        <= 1'b0;
            ties_reg         <= '0;
            emit_n_reg       <= '0;
            busy_reg         <= '0;
            hval_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            cur_reg       <= cur_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            pass2_reg     <= pass2_next;
            ties_reg      <= ties_next;
            emit_n_reg    <= emit_n_next;
            busy_reg      <= busy_next;
            hval_reg      <= hval_next;
            out_valid_reg <= out_valid_next;
            if (server_count_we)
            begin
                server_count_reg <= server_count_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            op_reg       <= action;
            arrival_reg  <= arrival_time;
            duration_reg <= duration;
        end
        tgt_reg     <= tgt_next;
        tgt_cnt_reg <= tgt_cnt_next;
        best_reg    <= best_next;
        kind_reg    <= kind_next;
        acc_reg     <= acc_next;
        srv_reg     <= srv_next;
        handled_reg <= handled_next;
        last_reg    <= last_next;
    end

    assign rsp_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign accepted  = acc_reg;
    assign server    = srv_reg;
    assign handled   = handled_reg;
    assign last      = last_reg;

    `BSD_ASSERT_NEXT(a_accept_leaves_idle, accept_in, state_reg != ST_IDLE,
        "accepted word did not start a sequence")
    `BSD_ASSERT_NEXT(a_done_loads_result, (state_reg == ST_DONE) && slot_free, rsp_valid,
        "assignment result not loaded into output register")
    `BSD_ASSERT_NOW(a_emit_has_ties, state_reg == ST_EMIT, ties_reg != '0,
        "report pass entered with no tied servers")
    `BSD_ASSERT_NOW(a_emit_bounded, state_reg == ST_EMIT, TW'(emit_n_reg) < TW'(MAX_RESULTS),
        "report emitted more entries than allowed")

endmodule

`default_nettype wire

FILE: test/busiest_server_dispatcher_checker.sv
// Checker for the busiest-server dispatcher: mirrors server state and compares every result word
`timescale 1ns / 1ps

module busiest_server_dispatcher_checker #(
    parameter int SERVERS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        server_count_we,
    input  logic [bsd_pkg::CFG_W-1:0]   server_count_wdata,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  logic                        action,
    input  logic [bsd_pkg::TIME_W-1:0]  arrival_time,
    input  logic [bsd_pkg::TIME_W-1:0]  duration,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  logic                        kind,
    input  logic                        accepted,
    input  logic [bsd_pkg::SRV_W-1:0]   server,
    input  logic [bsd_pkg::COUNT_W-1:0] handled,
    input  logic                        last,
    output int unsigned                 mismatch_count,
    output int unsigned                 outstanding
);
    import bsd_pkg::*;

    typedef struct packed {
        logic               kind;
        logic               accepted;
        logic [SRV_W-1:0]   server;
        logic [COUNT_W-1:0] handled;
        logic               last;
    } outcome_t;

    logic [CMP_W-1:0]   busy_until [SERVERS];
    logic               busy_flag [SERVERS];
    logic [COUNT_W-1:0] served [SERVERS];
    int unsigned        start_ptr;
    logic [CFG_W-1:0]   servers_cfg;
    outcome_t           awaited_outcomes [$];
    outcome_t           want_w;
    outcome_t           got_w;
    int unsigned        misses = 0;
    int                 s;

    assign mismatch_count = misses;

    task automatic note_miss(input string what, input outcome_t want, input outcome_t got);
        if (misses < 10)
        begin
            $display("%0t dispatcher mismatch (%s): expected kind=%0d acc=%0d srv=%0d",
                     $realtime, what, want.kind, want.accepted, want.server);
            $display("    expected handled=%0h last=%0d, got kind=%0d acc=%0d srv=%0d",
                     want.handled, want.last, got.kind, got.accepted, got.server);
            $display("    got handled=%0h last=%0d", got.handled, got.last);
        end
        misses++;
    endtask

    // Work out the result words that one accepted word causes
    task automatic dispatch_word(input logic act, input logic [TIME_W-1:0] t,
                                 input logic [TIME_W-1:0] d);
        int               k;
        int               i;
        int               idx;
        int               start;
        int               n;
        logic             found;
        int               pick;
        logic [COUNT_W-1:0] best;
        outcome_t         r;
        k = (servers_cfg == '0) ? 1 : ((servers_cfg > SERVERS) ? SERVERS : int'(servers_cfg));
        if (act == ACT_REQUEST)
        begin
            start = start_ptr % k;
            for (i = 0; i < k; i++)
                if (busy_flag[i] && busy_until[i] <= {1'b0, t})
                    busy_flag[i] = 1'b0;
            found = 1'b0;
            pick = 0;
            for (i = 0; i < k && !found; i++)
            begin
                idx = start + i;
                if (idx >= k)
                    idx -= k;
                if (!busy_flag[idx])
                begin
                    pick = idx;
                    found = 1'b1;
                end
            end
            start_ptr = (start + 1 >= k) ? 0 : start + 1;
            r = '0;
            r.kind = KIND_ASSIGN;
            r.last = 1'b1;
            if (found)
            begin
                busy_flag[pick] = 1'b1;
                busy_until[pick] = {1'b0, t} + {1'b0, d};
                if (served[pick] != '1)
                    served[pick] = served[pick] + 1'b1;
                r.accepted = 1'b1;
                r.server = pick[SRV_W-1:0];
                r.handled = served[pick];
            end
            awaited_outcomes.push_back(r);
        end
        else
        begin
            best = '0;
            for (i = 0; i < k; i++)
                if (served[i] > best)
                    best = served[i];
            n = 0;
            for (i = 0; i < k && n < MAX_RESULTS; i++)
            begin
                if (served[i] == best)
                begin
                    r = '0;
                    r.kind = KIND_REPORT;
                    r.server = i[SRV_W-1:0];
                    r.handled = best;
                    awaited_outcomes.push_back(r);
                    n++;
                end
            end
            // mark the final entry of this report
            if (n > 0)
            begin
                r = awaited_outcomes.pop_back();
                r.last = 1'b1;
                awaited_outcomes.push_back(r);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servers_cfg = SERVER_COUNT_RST;
            for (s = 0; s < SERVERS; s++)
            begin
                busy_until[s] = '0;
                busy_flag[s]  = 1'b0;
                served[s]     = '0;
            end
            start_ptr = 0;
            awaited_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (server_count_we)
                servers_cfg = server_count_wdata;
            if (rsp_valid && !rsp_stall)
            begin
                got_w.kind     = kind;
                got_w.accepted = accepted;
                got_w.server   = server;
                got_w.handled  = handled;
                got_w.last     = last;
                if (awaited_outcomes.size() == 0)
                begin
                    note_miss("no word awaited", '0, got_w);
                end
                else
                begin
                    want_w = awaited_outcomes.pop_front();
                    if (got_w.kind !== want_w.kind || got_w.accepted !== want_w.accepted ||
                        got_w.server !== want_w.server || got_w.handled !== want_w.handled ||
                        got_w.last !== want_w.last)
                        note_miss("field", want_w, got_w);
                end
            end
            if (req_valid && !req_stall)
                dispatch_word(action, arrival_time, duration);
            outstanding <= awaited_outcomes.size();
        end
    end

endmodule

FILE: test/busiest_server_dispatcher_core_tb.sv
// Testbench top for the busiest-server dispatcher: stimulus, output stalls and verdict
`timescale 1ns / 1ps

module busiest_server_dispatcher_core_tb;
    import bsd_pkg::*;

    localparam int SERVERS      = 16;
    localparam int DRAIN_CYCLES = 2 * SERVERS + 8;
    localparam int PHASE_WORDS  = 23;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS,
        STALL_PERIODIC
    } stall_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 server_count_we;
    logic [CFG_W-1:0]     server_count_wdata;
    logic                 req_valid;
    logic                 req_stall;
    logic                 action;
    logic [TIME_W-1:0]    arrival_time;
    logic [TIME_W-1:0]    duration;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic                 kind;
    logic                 accepted;
    logic [SRV_W-1:0]     server;
    logic [COUNT_W-1:0]   handled;
    logic                 last;
    int unsigned          mismatch_count;
    int unsigned          outstanding;

    int unsigned          burst_left = 0;
    logic [TIME_W-1:0]    arrival_now = '0;
    stall_mode_t          stall_mode = STALL_NONE;
    int unsigned          mode_left = 0;
    int unsigned          run_left = 0;
    int unsigned          pat_cnt = 0;
    logic [CFG_W-1:0]     phase_counts [10] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5,
                                               5'd17, 5'd8, 5'd3, 5'd16, 5'd12};

    busiest_server_dispatcher_core #(.NUM_SERVERS(SERVERS)) dut (.*);

    busiest_server_dispatcher_checker #(.SERVERS(SERVERS)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver stalls: the mode is redrawn whenever its random countdown runs out
    always @(posedge clk)
    begin
        pat_cnt <= pat_cnt + 1;
        if (mode_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(30, 150);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_RUNS:
            begin
                if (run_left == 0)
                begin
                    rsp_stall <= ~rsp_stall;
                    run_left  <= $urandom_range(1, 12);
                end
                else
                begin
                    run_left <= run_left - 1;
                end
            end
            default:      rsp_stall <= (pat_cnt % 5 < 2);
        endcase
    end

    // Offer one word and hold it until taken; bursts with random gaps
    task automatic send_word(input logic act, input logic [TIME_W-1:0] t,
                             input logic [TIME_W-1:0] d);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = $urandom_range(1, 16);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_valid    <= 1'b1;
        action       <= act;
        arrival_time <= t;
        duration     <= d;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        burst_left--;
    endtask

    // Drop valid and wait until every awaited word has come out
    task automatic drain();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_server_count(input logic [CFG_W-1:0] value);
        drain();
        server_count_we    <= 1'b1;
        server_count_wdata <= value;
        @(posedge clk);
        server_count_we    <= 1'b0;
    endtask

    task automatic random_phase(input int words);
        int               i;
        int unsigned      roll;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] d;
        roll = $urandom_range(0, 3);
        arrival_now = (roll == 0) ? '0 :
                      (roll == 1) ? TIME_W'(32'hFFFF_FF00) + $urandom_range(0, 200) :
                      $urandom();
        for (i = 0; i < words; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 14)
            begin
                send_word(ACT_REPORT, $urandom(), $urandom());
            end
            else
            begin
                if (roll < 19)
                begin
                    // step back in time; the running arrival is kept
                    t = arrival_now - $urandom_range(1, 50);
                end
                else
                begin
                    arrival_now = arrival_now + $urandom_range(0, 8);
                    t = arrival_now;
                end
                d = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 40);
                send_word(ACT_REQUEST, t, d);
            end
        end
    endtask

    initial
    begin
        int p;
        rst_n              <= 1'b0;
        server_count_we    <= 1'b0;
        server_count_wdata <= '0;
        req_valid          <= 1'b0;
        action             <= ACT_REQUEST;
        arrival_time       <= '0;
        duration           <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // nothing served yet: all servers tie at zero
        send_word(ACT_REPORT, '0, '0);
        send_word(ACT_REQUEST, 32'h0, 32'h0);
        send_word(ACT_REQUEST, 32'h0, 32'hFFFF_FFFF);
        send_word(ACT_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // arrival going backwards: later busy-until times hold
        send_word(ACT_REQUEST, 32'd5, 32'd3);
        send_word(ACT_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // shrink below the start pointer, then fill every server and drop
        set_server_count(5'd3);
        repeat (3) send_word(ACT_REQUEST, 32'd10, 32'd100);
        send_word(ACT_REPORT, '0, '0);
        // zero servers behaves as one
        set_server_count(5'd0);
        send_word(ACT_REQUEST, 32'd200, 32'd100);
        send_word(ACT_REQUEST, 32'd200, 32'd0);
        send_word(ACT_REPORT, '0, '0);
        // above the built count saturates; servers left out kept their state
        set_server_count(5'd31);
        send_word(ACT_REPORT, '0, '0);
        send_word(ACT_REQUEST, 32'hFFFF_FFFF, 32'd0);
        send_word(ACT_REQUEST, 32'hFFFF_FFFF, 32'd1);
        send_word(ACT_REPORT, '0, '0);

        for (p = 0; p < 10; p++)
        begin
            set_server_count(phase_counts[p]);
            random_phase(PHASE_WORDS);
        end

        drain();
        if (mismatch_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
